FILE: hw/rtl/apic_tmr_pkg.sv
// apic_tmr_pkg: shared types, register codes and a helper function for the
// countdown timer; used by every other module under hw/rtl but apic_tmr_checker
package apic_tmr_pkg;

    localparam int DATA_W = 32;
    localparam int VEC_W  = 8;
    localparam int PRE_W  = 7;
    localparam int DIV_W  = 4;

    // commands
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // register selects
    localparam logic [1:0] REG_LVT     = 2'd0;
    localparam logic [1:0] REG_INIT    = 2'd1;
    localparam logic [1:0] REG_CURRENT = 2'd2;
    localparam logic [1:0] REG_DIVIDE  = 2'd3;

    localparam int LVT_PERIODIC_BIT = 17;
    localparam logic [DIV_W-1:0] DIVIDE_KEEP_MASK = 4'hB;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [1:0]        reg_sel;
        logic [DATA_W-1:0] write_data;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_fire;
        logic [VEC_W-1:0]  irq_vector;
    } result_t;

    // true when this tick completes a prescaler period
    function automatic logic prescale_hit(input logic [DIV_W-1:0] code,
                                          input logic [PRE_W-1:0] pre);
        logic [2:0]     sel;
        logic [2:0]     shift;
        logic [PRE_W:0] ratio;
        sel   = {code[3], code[1:0]};
        shift = sel + 3'd1;
        ratio = (PRE_W+1)'(1) << shift;
        return ({1'b0, pre} + (PRE_W+1)'(1)) >= ratio;
    endfunction

endpackage

FILE: hw/rtl/apic_style_countdown_timer_top.sv
// Countdown timer of the local interrupt controller kind.
//
// s_ channel: one item per handshake, a clock tick (cmd 0), a register write
// (cmd 1) or a register read (cmd 2); reg_sel picks LVT, initial count,
// current count or divide configuration. m_ channel: exactly one result per
// item, in order: read data for reads, irq_fire/irq_vector when a tick takes
// the count to zero.
// The item waits in an input register and passes the timer logic into the
// result register once that register is empty or its result is being taken.
// Throughput is one item per cycle while m_ready stays high, set by the single
// pass through the timer logic between the two registers.
// When m_ready is low the result register holds its item; the input register
// still takes one more item, after which s_ready drops until the result is
// taken.
// aresetn (synchronous, active low) empties both registers and returns the
// timer to its reset state: count stopped, one-shot, vector zero, divide by
// two, prescaler cleared.
// depends on apic_tmr_pkg and the apic_tmr_* modules
module apic_style_countdown_timer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [1:0]  s_reg_sel,
    input  logic [31:0] s_write_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_data,
    output logic        m_irq_fire,
    output logic [7:0]  m_irq_vector
);

    apic_tmr_pkg::item_t   s_item;
    apic_tmr_pkg::item_t   item;
    apic_tmr_pkg::result_t result;
    apic_tmr_pkg::result_t m_result;
    logic                  item_valid;
    logic                  out_free;
    logic                  advance;

    assign s_item.cmd        = s_cmd;
    assign s_item.reg_sel    = s_reg_sel;
    assign s_item.write_data = s_write_data;

    // the held item is processed in the cycle it moves to the result register
    assign advance = item_valid && out_free;

    apic_tmr_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    apic_tmr_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (advance),
        .item    (item),
        .result  (result)
    );

    apic_tmr_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (result),
        .free     (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_read_data  = m_result.read_data;
    assign m_irq_fire   = m_result.irq_fire;
    assign m_irq_vector = m_result.irq_vector;

endmodule

FILE: hw/rtl/apic_tmr_in_stage.sv
// apic_tmr_in_stage: input register holding one accepted item
// depends on apic_tmr_pkg
module apic_tmr_in_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  apic_tmr_pkg::item_t  s_item,
    input  logic                 advance,
    output logic                 item_valid,
    output apic_tmr_pkg::item_t  item
);

    logic                valid_reg;
    logic                valid_next;
    apic_tmr_pkg::item_t item_reg;

    // free when empty or when the held item moves on this cycle
    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: hw/rtl/apic_tmr_core.sv
// apic_tmr_core: timer register file, prescaler and countdown; turns one item
// into one result per cycle while go is high. depends on apic_tmr_pkg
module apic_tmr_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   go,
    input  apic_tmr_pkg::item_t    item,
    output apic_tmr_pkg::result_t  result
);

    logic [apic_tmr_pkg::DATA_W-1:0] count_now_reg,    count_now_next;
    logic [apic_tmr_pkg::DATA_W-1:0] count_reload_reg, count_reload_next;
    logic [apic_tmr_pkg::DIV_W-1:0]  divide_code_reg,  divide_code_next;
    logic                            periodic_reg,     periodic_next;
    logic [apic_tmr_pkg::VEC_W-1:0]  vector_reg,       vector_next;
    logic [apic_tmr_pkg::PRE_W-1:0]  prescale_reg,     prescale_next;

    logic [apic_tmr_pkg::DATA_W-1:0] count_dec;

    assign count_dec = count_now_reg - apic_tmr_pkg::DATA_W'(1);

    always_comb begin
        count_now_next    = count_now_reg;
        count_reload_next = count_reload_reg;
        divide_code_next  = divide_code_reg;
        periodic_next     = periodic_reg;
        vector_next       = vector_reg;
        prescale_next     = prescale_reg;
        result            = '0;

        case (item.cmd)
            apic_tmr_pkg::CMD_TICK: begin
                // a stopped timer ignores ticks
                if (count_now_reg != '0) begin
                    if (apic_tmr_pkg::prescale_hit(divide_code_reg, prescale_reg)) begin
                        prescale_next  = '0;
                        count_now_next = count_dec;
                        if (count_dec == '0) begin
                            result.irq_fire   = 1'b1;
                            result.irq_vector = vector_reg;
                            if (periodic_reg) begin
                                count_now_next = count_reload_reg;
                            end
                        end
                    end else begin
                        prescale_next = prescale_reg + apic_tmr_pkg::PRE_W'(1);
                    end
                end
            end
            apic_tmr_pkg::CMD_WRITE: begin
                case (item.reg_sel)
                    apic_tmr_pkg::REG_LVT: begin
                        vector_next   = item.write_data[apic_tmr_pkg::VEC_W-1:0];
                        periodic_next = item.write_data[apic_tmr_pkg::LVT_PERIODIC_BIT];
                    end
                    apic_tmr_pkg::REG_INIT: begin
                        count_reload_next = item.write_data;
                        count_now_next    = item.write_data;
                        prescale_next     = '0;
                    end
                    apic_tmr_pkg::REG_DIVIDE: begin
                        divide_code_next = item.write_data[apic_tmr_pkg::DIV_W-1:0]
                                         & apic_tmr_pkg::DIVIDE_KEEP_MASK;
                        prescale_next    = '0;
                    end
                    default: begin
                        // current count is read only
                    end
                endcase
            end
            apic_tmr_pkg::CMD_READ: begin
                case (item.reg_sel)
                    apic_tmr_pkg::REG_LVT: begin
                        result.read_data = apic_tmr_pkg::DATA_W'(vector_reg);
                        result.read_data[apic_tmr_pkg::LVT_PERIODIC_BIT] = periodic_reg;
                    end
                    apic_tmr_pkg::REG_INIT: begin
                        result.read_data = count_reload_reg;
                    end
                    apic_tmr_pkg::REG_CURRENT: begin
                        result.read_data = count_now_reg;
                    end
                    default: begin
                        result.read_data = apic_tmr_pkg::DATA_W'(divide_code_reg);
                    end
                endcase
            end
            default: begin
                // unused command leaves everything alone
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_now_reg    <= '0;
            count_reload_reg <= '0;
            divide_code_reg  <= '0;
            periodic_reg     <= 1'b0;
            vector_reg       <= '0;
            prescale_reg     <= '0;
        end else if (go) begin
            count_now_reg    <= count_now_next;
            count_reload_reg <= count_reload_next;
            divide_code_reg  <= divide_code_next;
            periodic_reg     <= periodic_next;
            vector_reg       <= vector_next;
            prescale_reg     <= prescale_next;
        end
    end

endmodule

FILE: hw/rtl/apic_tmr_out_stage.sv
// apic_tmr_out_stage: result register in front of the m_ channel
// depends on apic_tmr_pkg
module apic_tmr_out_stage (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  apic_tmr_pkg::result_t  result,
    output logic                   free,
    output logic                   m_valid,
    input  logic                   m_ready,
    output apic_tmr_pkg::result_t  m_result
);

    logic                  valid_reg;
    logic                  valid_next;
    apic_tmr_pkg::result_t result_reg;

    assign free       = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

FILE: hw/rtl/apic_tmr_checker.sv
// apic_tmr_checker: port-level assertions for the countdown timer, bound to
// apic_style_countdown_timer_top
module apic_tmr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_read_data,
    input logic        m_irq_fire,
    input logic [7:0]  m_irq_vector
);

    // an item cannot be both a firing tick and a read
    a_fire_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_irq_fire |-> m_read_data == 32'd0)
        else $error("firing result carries read data");

    a_vector_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_irq_fire |-> m_irq_vector == 8'd0)
        else $error("vector shown without an interrupt");

    // once an accepted item has passed on, m_valid is high, with it or an older result
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> ##2 m_valid)
        else $error("accepted item did not reach the output");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data)
            && $stable(m_irq_fire) && $stable(m_irq_vector))
        else $error("stalled result changed");

endmodule

bind apic_style_countdown_timer_top apic_tmr_checker u_apic_tmr_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_read_data  (m_read_data),
    .m_irq_fire   (m_irq_fire),
    .m_irq_vector (m_irq_vector)
);

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// testbench for the countdown timer: drives ticks and register accesses over the
// s_ channel, predicts every result item and checks it on the m_ channel
// depends on apic_tmr_pkg and apic_style_countdown_timer_top

module testbench;
    import apic_tmr_pkg::*;

    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam logic [3:0] DIV_BY_1   = 4'hB;
    localparam logic [3:0] DIV_BY_2   = 4'h0;
    localparam logic [3:0] DIV_BY_4   = 4'h1;
    localparam logic [3:0] DIV_BY_128 = 4'hA;

    localparam int ITEM_TARGET    = 500;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int MAX_PRINTED    = 30;

    class timer_scoreboard;
        logic [31:0] cur_count;
        logic [31:0] init_count;
        logic [3:0]  div_code;
        logic        periodic;
        logic [7:0]  vector;
        logic [6:0]  prescale;
        result_t     expected_results[$];
        int          fail_count;

        function new();
            cur_count  = '0;
            init_count = '0;
            div_code   = DIV_BY_2;
            periodic   = 1'b0;
            vector     = '0;
            prescale   = '0;
            fail_count = 0;
        endfunction

        // ticks per decrement: bits 3,1,0 of the code pick a power of two
        function int ticks_per_step();
            int exp_sel;
            exp_sel = {div_code[3], div_code[1:0]};
            return 1 << ((exp_sel + 1) % 8);
        endfunction

        task report_mismatch(input string msg);
            if (fail_count < MAX_PRINTED)
                $display("mismatch at %0t: %s", $realtime, msg);
            fail_count++;
        endtask

        task predict_item(input item_t it);
            result_t res;
            res = '0;
            case (it.cmd)
                CMD_TICK: begin
                    // a stopped timer ignores ticks
                    if (cur_count != 0) begin
                        if (int'(prescale) + 1 >= ticks_per_step()) begin
                            prescale  = '0;
                            cur_count = cur_count - 1;
                            if (cur_count == 0) begin
                                res.irq_fire   = 1'b1;
                                res.irq_vector = vector;
                                if (periodic)
                                    cur_count = init_count;
                            end
                        end else begin
                            prescale = prescale + 1;
                        end
                    end
                end
                CMD_WRITE: begin
                    case (it.reg_sel)
                        REG_LVT: begin
                            vector   = it.write_data[7:0];
                            periodic = it.write_data[LVT_PERIODIC_BIT];
                        end
                        REG_INIT: begin
                            init_count = it.write_data;
                            cur_count  = it.write_data;
                            prescale   = '0;
                        end
                        REG_DIVIDE: begin
                            div_code = it.write_data[3:0] & DIVIDE_KEEP_MASK;
                            prescale = '0;
                        end
                        default: ;
                    endcase
                end
                CMD_READ: begin
                    case (it.reg_sel)
                        REG_LVT: begin
                            res.read_data = 32'(vector);
                            res.read_data[LVT_PERIODIC_BIT] = periodic;
                        end
                        REG_INIT:    res.read_data = init_count;
                        REG_CURRENT: res.read_data = cur_count;
                        default:     res.read_data = 32'(div_code);
                    endcase
                end
                default: ;
            endcase
            expected_results.push_back(res);
        endtask

        task check_result(input result_t got);
            result_t exp;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected item rd=%h fire=%b vec=%h",
                                          got.read_data, got.irq_fire, got.irq_vector));
                return;
            end
            exp = expected_results.pop_front();
            if (got.read_data !== exp.read_data)
                report_mismatch($sformatf("read_data %h, expected %h",
                                          got.read_data, exp.read_data));
            if (got.irq_fire !== exp.irq_fire)
                report_mismatch($sformatf("irq_fire %b, expected %b",
                                          got.irq_fire, exp.irq_fire));
            if (got.irq_vector !== exp.irq_vector)
                report_mismatch($sformatf("irq_vector %h, expected %h",
                                          got.irq_vector, exp.irq_vector));
        endtask
    endclass

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd        = CMD_TICK;
    logic [1:0]  s_reg_sel    = REG_LVT;
    logic [31:0] s_write_data = '0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [31:0] m_read_data;
    logic        m_irq_fire;
    logic [7:0]  m_irq_vector;

    timer_scoreboard sb;
    int idle_pct     = 0;
    int items_sent   = 0;
    int stall_left   = 0;
    int quiet_cycles = 0;

    always #2 aclk = ~aclk;

    apic_style_countdown_timer_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_reg_sel    (s_reg_sel),
        .s_write_data (s_write_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data),
        .m_irq_fire   (m_irq_fire),
        .m_irq_vector (m_irq_vector)
    );

    task automatic send_item(input logic [1:0] cmd, input logic [1:0] sel,
                             input logic [31:0] data);
        item_t it;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_reg_sel    <= sel;
        s_write_data <= data;
        do @(posedge aclk); while (!s_ready);
        it.cmd        = cmd;
        it.reg_sel    = sel;
        it.write_data = data;
        sb.predict_item(it);
        items_sent++;
    endtask

    // result side: check on handshake, stall in bursts
    always @(posedge aclk) begin
        result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.read_data  = m_read_data;
            got.irq_fire   = m_irq_fire;
            got.irq_vector = m_irq_vector;
            sb.check_result(got);
        end
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 14);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [3:0]  code;
        logic [31:0] data;
        int          run_len;
        bit          long_run;
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values, then the corner cases one by one
        send_item(CMD_READ, REG_LVT, '1);
        send_item(CMD_READ, REG_INIT, '1);
        send_item(CMD_READ, REG_CURRENT, '1);
        send_item(CMD_READ, REG_DIVIDE, '1);
        send_item(CMD_TICK, REG_INIT, '1);
        send_item(CMD_WRITE, REG_LVT, '1);
        send_item(CMD_READ, REG_LVT, '0);
        send_item(CMD_WRITE, REG_DIVIDE, '1);
        send_item(CMD_READ, REG_DIVIDE, '0);
        send_item(CMD_WRITE, REG_CURRENT, '1);
        send_item(CMD_WRITE, REG_INIT, 32'd2);
        repeat (4) send_item(CMD_TICK, REG_CURRENT, '0);
        // one-shot, vector 5a, all other bits set
        send_item(CMD_WRITE, REG_LVT, 32'hFFFD_FF5A);
        send_item(CMD_WRITE, REG_INIT, 32'd1);
        repeat (2) send_item(CMD_TICK, REG_LVT, '1);
        send_item(CMD_SPARE, REG_DIVIDE, '1);
        send_item(CMD_WRITE, REG_DIVIDE, 32'h0000_0004);
        send_item(CMD_WRITE, REG_INIT, '1);
        repeat (2) send_item(CMD_TICK, REG_DIVIDE, '1);
        send_item(CMD_READ, REG_CURRENT, '0);
        send_item(CMD_WRITE, REG_INIT, '0);
        send_item(CMD_READ, REG_INIT, '0);

        while (items_sent < ITEM_TARGET) begin
            if (items_sent > ITEM_TARGET * 4 / 5) begin
                idle_pct = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 10;
                    default: idle_pct = 35;
                endcase
            end
            long_run = ($urandom_range(0, 15) == 0);

            // programming sequence, with a step left out now and then
            if ($urandom_range(0, 3) != 0)
                send_item(CMD_WRITE, REG_LVT, $urandom);
            if (long_run) begin
                code = DIV_BY_128;
            end else begin
                case ($urandom_range(0, 5))
                    0:       code = 4'($urandom);
                    1, 2:    code = DIV_BY_1;
                    3, 4:    code = DIV_BY_2;
                    default: code = DIV_BY_4;
                endcase
            end
            if (long_run || $urandom_range(0, 3) != 0) begin
                data      = $urandom;
                data[3]   = code[3];
                data[1:0] = code[1:0];
                send_item(CMD_WRITE, REG_DIVIDE, data);
            end
            if (long_run) begin
                send_item(CMD_WRITE, REG_INIT, 32'd1);
            end else if ($urandom_range(0, 7) != 0) begin
                case ($urandom_range(0, 9))
                    0:       data = $urandom;
                    1:       data = '0;
                    default: data = $urandom_range(1, 6);
                endcase
                send_item(CMD_WRITE, REG_INIT, data);
            end

            // ticks with reads and the odd stray item mixed in
            run_len = long_run ? 135 : $urandom_range(3, 40);
            repeat (run_len) begin
                case ($urandom_range(0, 19))
                    0, 1, 2: send_item(CMD_READ, 2'($urandom), $urandom);
                    3:       send_item(2'($urandom), 2'($urandom), $urandom);
                    default: send_item(CMD_TICK, 2'($urandom), $urandom);
                endcase
            end
        end
        s_valid <= 1'b0;

        while (sb.expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.expected_results.size() != 0)
            sb.report_mismatch("result items still outstanding at end of run");
        if (sb.fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
